// ===== hdl/aes128_block_cipher_unit_macros.svh =====
// Assertion helpers for the block cipher unit.
`ifndef AES128_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES128_BLOCK_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AESBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block cipher check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define AESBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block cipher check failed");

`endif

// ===== hdl/aesbc_pkg.sv =====
`default_nettype none
package aesbc_pkg;

   localparam int unsigned ColWidth = 32;
   localparam logic [3:0] LastRound = 4'd10;

   typedef logic [127:0] block_type;
   typedef logic [31:0]  col_type;

   // Control into the round key unit
   typedef struct packed {
      logic       load;
      logic       step;
      logic [1:0] col;
      logic [7:0] rcon;
   } key_ctl_type;

   // Control into the data unit
   typedef struct packed {
      logic       load;
      logic       step;
      logic [1:0] col;
      logic       decrypt;
      logic       last_col;
      logic       last_round;
   } data_ctl_type;

   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX_TABLE [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Round constant for key schedule round 1..10
   function automatic logic [7:0] rcon(input logic [3:0] idx);
      case (idx)
         4'd1: rcon = 8'h01;
         4'd2: rcon = 8'h02;
         4'd3: rcon = 8'h04;
         4'd4: rcon = 8'h08;
         4'd5: rcon = 8'h10;
         4'd6: rcon = 8'h20;
         4'd7: rcon = 8'h40;
         4'd8: rcon = 8'h80;
         4'd9: rcon = 8'h1b;
         4'd10: rcon = 8'h36;
         default: rcon = 8'h00;
      endcase
   endfunction

   function automatic col_type mix_col(input col_type c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[7:0];
      a1 = c[15:8];
      a2 = c[23:16];
      a3 = c[31:24];
      mix_col[7:0]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mix_col[15:8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mix_col[23:16] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mix_col[31:24] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
   endfunction

   // Products by 9, 11, 13, 14 packed as {m14, m13, m11, m9}
   function automatic logic [31:0] inv_mults(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      inv_mults = {x8 ^ x4 ^ x2, x8 ^ x4 ^ a, x8 ^ x2 ^ a, x8 ^ a};
   endfunction

   function automatic col_type inv_mix_col(input col_type c);
      logic [31:0] m0, m1, m2, m3;
      m0 = inv_mults(c[7:0]);
      m1 = inv_mults(c[15:8]);
      m2 = inv_mults(c[23:16]);
      m3 = inv_mults(c[31:24]);
      inv_mix_col[7:0]   = m0[31:24] ^ m1[15:8]  ^ m2[23:16] ^ m3[7:0];
      inv_mix_col[15:8]  = m0[7:0]   ^ m1[31:24] ^ m2[15:8]  ^ m3[23:16];
      inv_mix_col[23:16] = m0[23:16] ^ m1[7:0]   ^ m2[31:24] ^ m3[15:8];
      inv_mix_col[31:24] = m0[15:8]  ^ m1[23:16] ^ m2[7:0]   ^ m3[31:24];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/aes128_block_cipher_unit.sv =====
`default_nettype none
// AES-128 block engine, electronic codebook use.
// Key: written through the APB port, key_low at byte address 0 and key_high at 8
// (address bit 3 selects the half). Each write starts a key expansion that walks
// the schedule one 32-bit column per cycle, with busy high; it keeps the last
// round key so decryption can run the schedule backward.
// Items: start with busy low and no register write takes req_command (0 encrypt,
// 1 decrypt) and the block halves. Each round is done one column per cycle
// through one column of S-boxes and one MixColumns unit, each with its inverse,
// the round key column made alongside. The result shows on rsp_result_low/high
// with rsp_strobe for one cycle. Busy stays high while an item runs and is
// already low in that cycle, so the next item can be accepted right away.
// Reset clears the key to zero and runs the expansion, so busy stays high after
// reset until it is done. The receiver cannot stall; results are taken as shown.
module aes128_block_cipher_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [63:0] req_block_low,
   input  wire logic [63:0] req_block_high,
   output logic             rsp_strobe,
   output logic [63:0]      rsp_result_low,
   output logic [63:0]      rsp_result_high,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   import aesbc_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_EXPAND = 2'd1;
   localparam logic [1:0] PH_ROUND  = 2'd2;

   localparam logic ADDR_KEY_LOW  = 1'b0;
   localparam logic ADDR_KEY_HIGH = 1'b1;

   logic [1:0] phase_ff, phase_in;
   logic [1:0] col_ff, col_in;
   logic [3:0] round_ff, round_in;
   logic       dec_ff, dec_in;
   logic       strobe_ff, strobe_in;
   block_type  key_ff, key_in, key_last_ff, key_last_in;
   logic       cfg_write, accept, last_col;
   block_type  round_key, state, load_block;
   col_type    key_col;
   key_ctl_type  kctl;
   data_ctl_type dctl;

   assign cfg_write = psel && penable && pwrite;
   assign busy      = (phase_ff != PH_IDLE);
   assign accept    = start && !busy && !cfg_write;
   assign last_col  = dec_ff ? (col_ff == 2'd0) : (col_ff == 2'd3);
   assign load_block = {req_block_high, req_block_low} ^ (req_command ? key_last_ff : key_ff);

   // Sequence expansion and rounds
   always_comb begin
      phase_in    = phase_ff;
      col_in      = col_ff;
      round_in    = round_ff;
      dec_in      = dec_ff;
      strobe_in   = 1'b0;
      key_in      = key_ff;
      key_last_in = key_last_ff;
      kctl        = '{load: 1'b0, step: 1'b0, col: col_ff, rcon: rcon(round_ff)};
      dctl        = '{load: accept, step: 1'b0, col: col_ff, decrypt: dec_ff,
                      last_col: last_col, last_round: (round_ff == LastRound)};
      if (cfg_write) begin
         case (paddr[3])
            ADDR_KEY_LOW:  key_in[63:0]   = pwdata;
            ADDR_KEY_HIGH: key_in[127:64] = pwdata;
            default:       key_in         = key_ff;
         endcase
         kctl.load = 1'b1;
         phase_in  = PH_EXPAND;
         col_in    = 2'd0;
         round_in  = 4'd1;
         dec_in    = 1'b0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (accept) begin
                  kctl.load = 1'b1;
                  phase_in  = PH_ROUND;
                  dec_in    = req_command;
                  col_in    = req_command ? 2'd3 : 2'd0;
                  round_in  = 4'd1;
               end
            end
            PH_EXPAND: begin
               kctl.step = 1'b1;
               col_in    = col_ff + 2'd1;
               if (col_ff == 2'd3) begin
                  round_in = round_ff + 4'd1;
                  if (round_ff == LastRound) begin
                     key_last_in = {key_col, round_key[95:0]};
                     phase_in    = PH_IDLE;
                  end
               end
            end
            PH_ROUND: begin
               kctl.step = 1'b1;
               dctl.step = 1'b1;
               if (dec_ff) begin
                  kctl.rcon = rcon(4'd11 - round_ff);
               end
               col_in = dec_ff ? (col_ff - 2'd1) : (col_ff + 2'd1);
               if (last_col) begin
                  round_in = round_ff + 4'd1;
                  if (round_ff == LastRound) begin
                     phase_in  = PH_IDLE;
                     strobe_in = 1'b1;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_EXPAND;
         col_ff    <= 2'd0;
         round_ff  <= 4'd1;
         dec_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         key_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         col_ff    <= col_in;
         round_ff  <= round_in;
         dec_ff    <= dec_in;
         strobe_ff <= strobe_in;
         key_ff    <= key_in;
      end
   end

   // Hold the last round key for decryption
   always_ff @(posedge clock) begin
      key_last_ff <= key_last_in;
   end

   aesbc_key_col u_key (
      .clock     (clock),
      .reset     (reset),
      .ctl       (kctl),
      .load_key  (cfg_write ? key_in : (req_command ? key_last_ff : key_ff)),
      .key_col   (key_col),
      .round_key (round_key)
   );

   aesbc_data_col u_data (
      .clock      (clock),
      .ctl        (dctl),
      .load_block (load_block),
      .key_col    (key_col),
      .state      (state)
   );

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_low  = state[63:0];
   assign rsp_result_high = state[127:64];
   assign prdata          = paddr[3] ? key_ff[127:64] : key_ff[63:0];
   assign pready          = 1'b1;

`include "aes128_block_cipher_unit_macros.svh"

   `AESBC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `AESBC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_strobe)
   `AESBC_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
endmodule
`default_nettype wire

// ===== hdl/aesbc_key_col.sv =====
`default_nettype none
module aesbc_key_col (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire aesbc_pkg::key_ctl_type  ctl,
   input  wire aesbc_pkg::block_type    load_key,
   output aesbc_pkg::col_type           key_col,
   output aesbc_pkg::block_type         round_key
);
   import aesbc_pkg::*;

   block_type rk_ff, rk_in;
   col_type   w_cur, w_prev, w_last, g_word;
   logic [1:0] prev_col;

   // One round key column per cycle, updated in place
   always_comb begin
      prev_col = ctl.col - 2'd1;
      w_cur  = rk_ff[ColWidth*ctl.col +: ColWidth];
      w_prev = rk_ff[ColWidth*prev_col +: ColWidth];
      w_last = rk_ff[127:96];
      g_word = {SBOX_TABLE[w_last[7:0]], SBOX_TABLE[w_last[31:24]],
                SBOX_TABLE[w_last[23:16]], SBOX_TABLE[w_last[15:8]] ^ ctl.rcon};
      key_col = (ctl.col == 2'd0) ? (w_cur ^ g_word) : (w_cur ^ w_prev);
   end

   always_comb begin
      rk_in = rk_ff;
      if (ctl.load) begin
         rk_in = load_key;
      end else if (ctl.step) begin
         rk_in[ColWidth*ctl.col +: ColWidth] = key_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rk_ff <= '0;
      end else begin
         rk_ff <= rk_in;
      end
   end

   assign round_key = rk_ff;
endmodule
`default_nettype wire

// ===== hdl/aesbc_data_col.sv =====
`default_nettype none
module aesbc_data_col (
   input  wire logic                    clock,
   input  wire aesbc_pkg::data_ctl_type ctl,
   input  wire aesbc_pkg::block_type    load_block,
   input  wire aesbc_pkg::col_type      key_col,
   output aesbc_pkg::block_type         state
);
   import aesbc_pkg::*;

   block_type st_ff, nx_ff, nx_in;
   col_type   sub_col, col_out, added;
   logic [1:0] src [4];

   // Gather the shifted column, substitute its bytes, mix and add the round key
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         src[r] = ctl.decrypt ? (ctl.col - 2'(r)) : (ctl.col + 2'(r));
         if (ctl.decrypt) begin
            sub_col[8*r +: 8] = INV_SBOX_TABLE[st_ff[{src[r], 2'(r), 3'b000} +: 8]];
         end else begin
            sub_col[8*r +: 8] = SBOX_TABLE[st_ff[{src[r], 2'(r), 3'b000} +: 8]];
         end
      end
      if (ctl.decrypt) begin
         added   = sub_col ^ key_col;
         col_out = ctl.last_round ? added : inv_mix_col(added);
      end else begin
         added   = ctl.last_round ? sub_col : mix_col(sub_col);
         col_out = added ^ key_col;
      end
      nx_in = nx_ff;
      nx_in[ColWidth*ctl.col +: ColWidth] = col_out;
   end

   // Collect new columns, commit the state after the last one
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         st_ff <= load_block;
      end else if (ctl.step) begin
         nx_ff <= nx_in;
         if (ctl.last_col) begin
            st_ff <= nx_in;
         end
      end
   end

   assign state = st_ff;
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit        cmd;
      bit [63:0] lo;
      bit [63:0] hi;
   } cipher_item_type;

   localparam bit CMD_ENCRYPT = 1'b0;
   localparam bit CMD_DECRYPT = 1'b1;
   localparam logic [3:0] ADDR_KEY_LOW  = 4'd0;
   localparam logic [3:0] ADDR_KEY_HIGH = 4'd8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = 1'b0;
   logic [63:0] req_block_low = '0;
   logic [63:0] req_block_high = '0;
   logic        rsp_strobe;
   logic [63:0] rsp_result_low;
   logic [63:0] rsp_result_high;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   aes128_block_cipher_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_block_low(req_block_low),
      .req_block_high(req_block_high), .rsp_strobe(rsp_strobe),
      .rsp_result_low(rsp_result_low), .rsp_result_high(rsp_result_high),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: S-box tables, current key and round key schedules
   bit [7:0]   sbox_lut [256];
   bit [7:0]   inv_sbox_lut [256];
   bit [127:0] cipher_key;
   bit [127:0] enc_rk [11];
   bit [127:0] dec_rk [11];

   cipher_item_type pending_items [$];
   bit [127:0]   expected_blocks [$];
   int unsigned  idle_pct = 0;
   int unsigned  err_count = 0;
   int unsigned  items_sent = 0;
   int unsigned  results_seen = 0;
   int unsigned  key_writes = 0;
   bit [127:0]   accepted_block;

   function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
      bit [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   // Fill forward and inverse S-box from the field inverse and affine map
   function automatic void build_sbox();
      bit [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'd1;
         for (int i = 0; i < 254; i++) inv = gf_mul(inv, x[7:0]);
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sbox_lut[x] = s;
         inv_sbox_lut[s] = x[7:0];
      end
   endfunction

   function automatic bit [31:0] mix_word(bit [31:0] c, bit inverse);
      bit [7:0] m [4];
      bit [31:0] r;
      if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      r = 0;
      for (int row = 0; row < 4; row++)
         for (int k = 0; k < 4; k++)
            r[8*row +: 8] ^= gf_mul(c[8*k +: 8], m[(k - row + 4) % 4]);
      return r;
   endfunction

   // Expand the current key into both schedules
   function automatic void expand_schedule();
      bit [7:0] w [176];
      bit [7:0] t [4];
      bit [7:0] rc, x;
      bit [127:0] rk;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) w[i] = cipher_key[8*i +: 8];
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) t[j] = w[i - 4 + j];
         if ((i % 16) == 0) begin
            x = t[0];
            t[0] = sbox_lut[t[1]] ^ rc;
            t[1] = sbox_lut[t[2]];
            t[2] = sbox_lut[t[3]];
            t[3] = sbox_lut[x];
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end
         for (int j = 0; j < 4; j++) w[i + j] = w[i - 16 + j] ^ t[j];
      end
      for (int r = 0; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) rk[8*i +: 8] = w[16*r + i];
         enc_rk[r] = rk;
      end
      for (int r = 0; r <= 10; r++) begin
         rk = enc_rk[10 - r];
         if (r != 0 && r != 10)
            for (int c = 0; c < 4; c++) rk[32*c +: 32] = mix_word(rk[32*c +: 32], 1'b1);
         dec_rk[r] = rk;
      end
   endfunction

   function automatic bit [127:0] transform_block(bit [127:0] blk, bit cmd);
      bit [127:0] s, t;
      s = blk ^ ((cmd == CMD_DECRYPT) ? dec_rk[0] : enc_rk[0]);
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               if (cmd == CMD_DECRYPT)
                  t[8*(w + 4*((c + w) % 4)) +: 8] = inv_sbox_lut[s[8*(w + 4*c) +: 8]];
               else
                  t[8*(w + 4*c) +: 8] = sbox_lut[s[8*(w + 4*((c + w) % 4)) +: 8]];
         if (r != 10)
            for (int c = 0; c < 4; c++) t[32*c +: 32] = mix_word(t[32*c +: 32], cmd);
         s = t ^ ((cmd == CMD_DECRYPT) ? dec_rk[r] : enc_rk[r]);
      end
      return s;
   endfunction

   // Driver: record the accepted item's expected block, then present the next item
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accepted_block = transform_block({req_block_high, req_block_low}, req_command);
            expected_blocks.push_back(accepted_block);
            items_sent++;
         end
         if (!start || !busy) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               start <= 1'b1;
               req_command <= pending_items[0].cmd;
               req_block_low <= pending_items[0].lo;
               req_block_high <= pending_items[0].hi;
               void'(pending_items.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_blocks.size() == 0) begin
            $error("unexpected result low=%h high=%h", rsp_result_low, rsp_result_high);
            err_count++;
         end else begin
            if (rsp_result_low !== expected_blocks[0][63:0]) begin
               $error("result_low expected %h actual %h", expected_blocks[0][63:0],
                      rsp_result_low);
               err_count++;
            end
            if (rsp_result_high !== expected_blocks[0][127:64]) begin
               $error("result_high expected %h actual %h", expected_blocks[0][127:64],
                      rsp_result_high);
               err_count++;
            end
            void'(expected_blocks.pop_front());
         end
      end
   end

   task automatic push_item(bit cmd, bit [63:0] lo, bit [63:0] hi);
      cipher_item_type it;
      it.cmd = cmd;
      it.lo = lo;
      it.hi = hi;
      pending_items.push_back(it);
   endtask

   // Hold off until every item is sent and every result is back
   task automatic drain();
      while (pending_items.size() > 0 || start || expected_blocks.size() > 0)
         @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   // Two-phase register write; update the predictor's key at the same edge
   task automatic write_key_half(logic [3:0] addr, bit [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_KEY_LOW) cipher_key[63:0] = value;
      else cipher_key[127:64] = value;
      expand_schedule();
      key_writes++;
      repeat (2) @(posedge clock);
   endtask

   task automatic load_key(bit [63:0] lo, bit [63:0] hi);
      drain();
      write_key_half(ADDR_KEY_LOW, lo);
      write_key_half(ADDR_KEY_HIGH, hi);
   endtask

   function automatic bit [63:0] rand64();
      bit [63:0] v;
      case ($urandom_range(9))
         0: v = '0;
         1: v = '1;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Directed cases on fixed blocks, both commands
   task automatic push_directed();
      push_item(CMD_ENCRYPT, '0, '0);
      push_item(CMD_DECRYPT, '0, '0);
      push_item(CMD_ENCRYPT, '1, '1);
      push_item(CMD_DECRYPT, '1, '1);
      push_item(CMD_ENCRYPT, 64'h7766554433221100, 64'hffeeddccbbaa9988);
      push_item(CMD_DECRYPT, 64'hd8e0c469_30047b6a, 64'h5ac5b470_80b7cdd8);
      push_item(CMD_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
   endtask

   initial begin
      bit [63:0] klo, khi;
      build_sbox();
      cipher_key = '0;
      expand_schedule();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset key, then the standard test key, then an all-ones key
      push_directed();
      load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
      push_directed();
      load_key('1, '1);
      push_directed();

      // Random blocks under a series of keys, three idling profiles
      for (int phase = 0; phase < 3; phase++) begin
         for (int seg = 0; seg < 6; seg++) begin
            klo = rand64();
            khi = rand64();
            if (seg == 0 && phase == 2) begin
               klo = '0;
               khi = '0;
            end
            load_key(klo, khi);
            idle_pct = (phase == 0) ? 29 : (phase == 1) ? 84 : 0;
            for (int n = 0; n < 100; n++)
               push_item(1'($urandom_range(1)), rand64(), rand64());
         end
      end
      drain();

      $display("tb_top: %0d items, %0d results, %0d key register writes, both commands",
               items_sent, results_seen, key_writes);
      if (err_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/aesbc_pkg.sv
hdl/aesbc_key_col.sv
hdl/aesbc_data_col.sv
hdl/aes128_block_cipher_unit.sv
test/tb_top.sv
